// ===== hw/rtl/gql_pkg.sv =====
// gql_pkg: shared types, constants and helpers of the glyph quad layout block
// command and result codes, stream payloads, glyph table entry, saturation
// no dependencies
package gql_pkg;

  localparam int POS_W   = 20;
  localparam int TEX_W   = 16;
  localparam int MET_W   = 16;
  localparam int CNT_W   = 16;
  localparam int ATLAS_W = 13;
  localparam int GIDX_W  = 7;
  localparam int CODE_W  = 8;
  localparam int SIZE_W  = 17;  // (16 bit span * 13 bit atlas) >> 12
  localparam int BOX_W   = 21;  // pen + offset, exact
  localparam int EDGE_W  = 23;  // pen + offset + size, exact
  localparam int CODE_OFF_W = 10;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [2:0] VTX_FIRST = 3'd0;
  localparam logic [2:0] VTX_LAST  = 3'd5;
  localparam logic [ATLAS_W-1:0] ATLAS_RESET = 13'd512;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_CHAR  = 2'd2,
    CMD_END   = 2'd3
  } cmd_e;

  typedef enum logic {
    KIND_VERTEX = 1'b0,
    KIND_COUNT  = 1'b1
  } kind_e;

  typedef enum logic [0:0] {
    REG_ATLAS_WIDTH  = 1'b0,
    REG_ATLAS_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic [GIDX_W-1:0]        glyph_index;
    logic [TEX_W-1:0]         rect_u0;
    logic [TEX_W-1:0]         rect_v0;
    logic [TEX_W-1:0]         rect_u1;
    logic [TEX_W-1:0]         rect_v1;
    logic signed [MET_W-1:0]  offset_x;
    logic signed [MET_W-1:0]  offset_y;
    logic signed [MET_W-1:0]  advance;
    logic [CODE_W-1:0]        char_code;
    logic signed [POS_W-1:0]  start_x;
    logic signed [POS_W-1:0]  start_y;
  } item_t;

  typedef struct packed {
    kind_e                    kind;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [TEX_W-1:0]         tex_u;
    logic [TEX_W-1:0]         tex_v;
    logic                     last;
    logic [CNT_W-1:0]         quad_count;
  } vertex_t;

  typedef struct packed {
    logic [TEX_W-1:0]         u0;
    logic [TEX_W-1:0]         v0;
    logic [TEX_W-1:0]         u1;
    logic [TEX_W-1:0]         v1;
    logic signed [MET_W-1:0]  ox;
    logic signed [MET_W-1:0]  oy;
    logic signed [MET_W-1:0]  adv;
  } glyph_t;

  // one quad (or count report) between the calc stage and the vertex emitter
  typedef struct packed {
    kind_e                    kind;
    logic [SIZE_W-1:0]        w;
    logic [SIZE_W-1:0]        h;
    logic signed [BOX_W-1:0]  bx;
    logic signed [BOX_W-1:0]  by;
    logic [TEX_W-1:0]         u0;
    logic [TEX_W-1:0]         v0;
    logic [TEX_W-1:0]         u1;
    logic [TEX_W-1:0]         v1;
    logic [CNT_W-1:0]         count;
  } quad_t;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [EDGE_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > 23'sd524287) begin
      r = 20'sh7FFFF;
    end else if (v < -23'sd524288) begin
      r = 20'sh80000;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/gql_stream_if.sv =====
// gql_stream_if: valid/ready stream channel with a typed payload
// payload type set by the instantiating level, normally from gql_pkg
interface gql_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/gql_glyph_mem.sv =====
// gql_glyph_mem: glyph table, one write and one registered read per cycle
// per-entry valid bits make unwritten entries read as zero; uses gql_pkg
module gql_glyph_mem #(
  parameter int GLYPH_COUNT = 95,
  parameter int IDX_W = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [IDX_W-1:0]      wr_addr_i,
  input  gql_pkg::glyph_t       wr_data_i,
  input  logic                  rd_en_i,
  input  logic [IDX_W-1:0]      rd_addr_i,
  output gql_pkg::glyph_t       rd_data_o
);
  import gql_pkg::*;

  glyph_t                 mem [GLYPH_COUNT];
  logic [GLYPH_COUNT-1:0] vld_q;
  glyph_t                 rd_q;
  logic                   rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

// ===== hw/rtl/gql_quad_calc.sv =====
// gql_quad_calc: command decode, pen and quad count state, glyph size multiply
// drives the glyph table ports and hands quads to the emitter; uses gql_pkg
module gql_quad_calc #(
  parameter int GLYPH_COUNT = 95,
  parameter int FIRST_CODE = 32,
  parameter int IDX_W = 7
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [0:0]                     cfg_idx_i,
  input  logic [gql_pkg::ATLAS_W-1:0]    cfg_wdata_i,
  input  logic                           in_valid_i,
  input  gql_pkg::item_t                 in_data_i,
  output logic                           in_ready_o,
  output logic                           wr_en_o,
  output logic [IDX_W-1:0]               wr_addr_o,
  output gql_pkg::glyph_t                wr_data_o,
  output logic                           rd_en_o,
  output logic [IDX_W-1:0]               rd_addr_o,
  input  gql_pkg::glyph_t                rd_data_i,
  output logic                           quad_vld_o,
  output gql_pkg::quad_t                 quad_o,
  input  logic                           quad_take_i
);
  import gql_pkg::*;

  logic [ATLAS_W-1:0]      atlas_w_q, atlas_h_q;
  logic signed [POS_W-1:0] pen_x_q, pen_x_d, pen_y_q, pen_y_d;
  logic [CNT_W-1:0]        quads_q, quads_d;

  logic                    s1_vld_q;
  cmd_e                    s1_cmd_q;
  logic                    s1_pr_q;
  logic signed [POS_W-1:0] s1_sx_q, s1_sy_q;

  logic                    s2_vld_q;
  quad_t                   s2_q, s2_d;

  logic                    in_fire, s1_fire, s1_emits, nonempty, s2_ready;
  logic [CODE_OFF_W-1:0]   code_ext, code_off, gidx_ext;
  logic                    printable, load_ok;
  logic [TEX_W-1:0]        du, dv;
  logic [TEX_W+ATLAS_W-1:0] w_full, h_full;
  logic signed [BOX_W-1:0] adv_sum;

  // decode at acceptance
  assign in_fire   = in_valid_i && in_ready_o;
  assign code_ext  = CODE_OFF_W'(in_data_i.char_code);
  assign code_off  = code_ext - CODE_OFF_W'(FIRST_CODE);
  assign printable = (code_ext >= CODE_OFF_W'(FIRST_CODE))
                     && (code_off < CODE_OFF_W'(GLYPH_COUNT));
  assign gidx_ext  = CODE_OFF_W'(in_data_i.glyph_index);
  assign load_ok   = gidx_ext < CODE_OFF_W'(GLYPH_COUNT);

  assign wr_en_o   = in_fire && (in_data_i.cmd == CMD_LOAD) && load_ok;
  assign wr_addr_o = IDX_W'(in_data_i.glyph_index);
  assign wr_data_o = '{u0: in_data_i.rect_u0, v0: in_data_i.rect_v0,
                       u1: in_data_i.rect_u1, v1: in_data_i.rect_v1,
                       ox: in_data_i.offset_x, oy: in_data_i.offset_y,
                       adv: in_data_i.advance};
  assign rd_en_o   = in_fire && (in_data_i.cmd == CMD_CHAR) && printable;
  assign rd_addr_o = code_off[IDX_W-1:0];

  // stage 1: glyph entry is in from the table
  assign nonempty = (rd_data_i.u1 > rd_data_i.u0) && (rd_data_i.v1 > rd_data_i.v0);
  assign s1_emits = (s1_cmd_q == CMD_END) || ((s1_cmd_q == CMD_CHAR) && s1_pr_q && nonempty);
  assign s2_ready = !s2_vld_q || quad_take_i;
  assign s1_fire  = s1_vld_q && (!s1_emits || s2_ready);
  assign in_ready_o = !s1_vld_q || s1_fire;

  assign du      = rd_data_i.u1 - rd_data_i.u0;
  assign dv      = rd_data_i.v1 - rd_data_i.v0;
  assign w_full  = (TEX_W+ATLAS_W)'(du) * (TEX_W+ATLAS_W)'(atlas_w_q);
  assign h_full  = (TEX_W+ATLAS_W)'(dv) * (TEX_W+ATLAS_W)'(atlas_h_q);
  assign adv_sum = {pen_x_q[POS_W-1], pen_x_q}
                   + {{(BOX_W-MET_W){rd_data_i.adv[MET_W-1]}}, rd_data_i.adv};

  always_comb begin
    s2_d       = '0;
    s2_d.kind  = (s1_cmd_q == CMD_END) ? KIND_COUNT : KIND_VERTEX;
    s2_d.w     = w_full[TEX_W+ATLAS_W-1:12];
    s2_d.h     = h_full[TEX_W+ATLAS_W-1:12];
    s2_d.bx    = {pen_x_q[POS_W-1], pen_x_q}
                 + {{(BOX_W-MET_W){rd_data_i.ox[MET_W-1]}}, rd_data_i.ox};
    s2_d.by    = {pen_y_q[POS_W-1], pen_y_q}
                 + {{(BOX_W-MET_W){rd_data_i.oy[MET_W-1]}}, rd_data_i.oy};
    s2_d.u0    = rd_data_i.u0;
    s2_d.v0    = rd_data_i.v0;
    s2_d.u1    = rd_data_i.u1;
    s2_d.v1    = rd_data_i.v1;
    s2_d.count = quads_q;
  end

  always_comb begin
    pen_x_d = pen_x_q;
    pen_y_d = pen_y_q;
    quads_d = quads_q;
    case (s1_cmd_q)
      CMD_START: begin
        pen_x_d = s1_sx_q;
        pen_y_d = s1_sy_q;
        quads_d = '0;
      end
      CMD_CHAR: begin
        if (s1_pr_q) begin
          pen_x_d = sat_pos({{(EDGE_W-BOX_W){adv_sum[BOX_W-1]}}, adv_sum});
          if (nonempty && (quads_q != CNT_MAX)) begin
            quads_d = quads_q + CNT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_w_q <= ATLAS_RESET;
      atlas_h_q <= ATLAS_RESET;
      pen_x_q   <= '0;
      pen_y_q   <= '0;
      quads_q   <= '0;
      s1_vld_q  <= 1'b0;
      s1_cmd_q  <= CMD_LOAD;
      s2_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_ATLAS_WIDTH:  atlas_w_q <= cfg_wdata_i;
          REG_ATLAS_HEIGHT: atlas_h_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (s1_fire) begin
        pen_x_q <= pen_x_d;
        pen_y_q <= pen_y_d;
        quads_q <= quads_d;
      end
      if (in_ready_o) begin
        s1_vld_q <= in_valid_i;
      end
      if (in_fire) begin
        s1_cmd_q <= in_data_i.cmd;
      end
      if (s1_fire && s1_emits) begin
        s2_vld_q <= 1'b1;
      end else if (quad_take_i) begin
        s2_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pr_q <= printable;
      s1_sx_q <= in_data_i.start_x;
      s1_sy_q <= in_data_i.start_y;
    end
    if (s1_fire && s1_emits) begin
      s2_q <= s2_d;
    end
  end

  assign quad_vld_o = s2_vld_q;
  assign quad_o     = s2_q;

endmodule

// ===== hw/rtl/gql_vertex_emit.sv =====
// gql_vertex_emit: edge saturation and six-beat vertex sequencer
// holds one quad or count report as the output register; uses gql_pkg
module gql_vertex_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              quad_vld_i,
  input  gql_pkg::quad_t    quad_i,
  output logic              quad_take_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gql_pkg::vertex_t  out_data_o
);
  import gql_pkg::*;

  logic                    vld_q;
  logic [2:0]              beat_q;
  kind_e                   kind_q;
  logic signed [POS_W-1:0] x0_q, x1_q, y0_q, y1_q;
  logic [TEX_W-1:0]        u0_q, v0_q, u1_q, v1_q;
  logic [CNT_W-1:0]        cnt_q;

  logic                    xfer, done, sel_hi_x, sel_hi_y;
  logic signed [EDGE_W-1:0] bx_e, by_e;

  assign xfer = vld_q && out_ready_i;
  assign done = xfer && ((kind_q == KIND_COUNT) || (beat_q == VTX_LAST));
  assign quad_take_o = !vld_q || done;

  assign bx_e = {{(EDGE_W-BOX_W){quad_i.bx[BOX_W-1]}}, quad_i.bx};
  assign by_e = {{(EDGE_W-BOX_W){quad_i.by[BOX_W-1]}}, quad_i.by};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      beat_q <= VTX_FIRST;
      kind_q <= KIND_VERTEX;
    end else begin
      if (quad_take_o) begin
        vld_q  <= quad_vld_i;
        beat_q <= VTX_FIRST;
        if (quad_vld_i) begin
          kind_q <= quad_i.kind;
        end
      end else if (xfer) begin
        beat_q <= beat_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (quad_take_o && quad_vld_i) begin
      x0_q  <= sat_pos(bx_e);
      y0_q  <= sat_pos(by_e);
      x1_q  <= sat_pos(bx_e + EDGE_W'(quad_i.w));
      y1_q  <= sat_pos(by_e + EDGE_W'(quad_i.h));
      u0_q  <= quad_i.u0;
      v0_q  <= quad_i.v0;
      u1_q  <= quad_i.u1;
      v1_q  <= quad_i.v1;
      cnt_q <= quad_i.count;
    end
  end

  // beats: (x0,y0) (x0,y1) (x1,y0) (x1,y0) (x0,y1) (x1,y1)
  always_comb begin
    sel_hi_x = 1'b0;
    sel_hi_y = 1'b0;
    case (beat_q)
      3'd1, 3'd4: sel_hi_y = 1'b1;
      3'd2, 3'd3: sel_hi_x = 1'b1;
      3'd5: begin
        sel_hi_x = 1'b1;
        sel_hi_y = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_data_o = '0;
    out_data_o.kind = kind_q;
    if (kind_q == KIND_COUNT) begin
      out_data_o.last       = 1'b1;
      out_data_o.quad_count = cnt_q;
    end else begin
      out_data_o.pos_x = sel_hi_x ? x1_q : x0_q;
      out_data_o.tex_u = sel_hi_x ? u1_q : u0_q;
      out_data_o.pos_y = sel_hi_y ? y1_q : y0_q;
      out_data_o.tex_v = sel_hi_y ? v1_q : v0_q;
      out_data_o.last  = (beat_q == VTX_LAST);
    end
  end

  assign out_valid_o = vld_q;

endmodule

// ===== hw/rtl/glyph_quad_layout.sv =====
// glyph_quad_layout: text-to-quad engine for a bitmap font atlas, top level
// depends on gql_pkg, gql_stream_if, gql_glyph_mem, gql_quad_calc, gql_vertex_emit
//
// usage:
//   item_i carries commands (load glyph, start string, character, end string);
//   vertex_o carries vertex transactions and quad count reports.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write atlas width (0) and height (1), only
//   while the block is idle.
// path: a character transaction reads the glyph table at the edge that accepts
//   it; the command stage sizes the quad from the entry, the quad stage holds
//   it and the emitter register offers its first vertex on vertex_o, an end
//   string report likewise.
// throughput: one command per cycle for loads, starts, unprintable codes and
//   empty glyphs unless a quad stalls in the command stage; a printable glyph
//   gives six vertices, one per cycle while vertex_o is ready (single result
//   channel); the next character is taken and sized as a quad drains: no gaps.
// reset: the glyph table reads as zero (valid bit per entry), pen and count are
//   zero, atlas size is 512 x 512; no clearing pass is needed.
// stall: when vertex_o is not ready the emitter holds its vertex, the quad
//   stage and the command stage fill, and item_i.ready drops.
// the table is written and read only at acceptance, one command per edge, so
//   a read never meets a write to the same entry in the same cycle
module glyph_quad_layout #(
  parameter int GLYPH_COUNT = 95,
  parameter int FIRST_CODE = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [0:0]                   cfg_idx_i,
  input  logic [gql_pkg::ATLAS_W-1:0]  cfg_wdata_i,
  gql_stream_if.sink                   item_i,
  gql_stream_if.source                 vertex_o
);
  import gql_pkg::*;

  localparam int IDX_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

  // glyph table ports
  logic              wr_en, rd_en;
  logic [IDX_W-1:0]  wr_addr, rd_addr;
  glyph_t            wr_data, rd_data;

  // calc to emitter
  logic              quad_vld, quad_take;
  quad_t             quad;
  vertex_t           vtx;

  gql_glyph_mem #(
    .GLYPH_COUNT(GLYPH_COUNT),
    .IDX_W      (IDX_W)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  gql_quad_calc #(
    .GLYPH_COUNT(GLYPH_COUNT),
    .FIRST_CODE (FIRST_CODE),
    .IDX_W      (IDX_W)
  ) u_calc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (item_i.valid),
    .in_data_i  (item_i.data),
    .in_ready_o (item_i.ready),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .quad_vld_o (quad_vld),
    .quad_o     (quad),
    .quad_take_i(quad_take)
  );

  gql_vertex_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .quad_vld_i (quad_vld),
    .quad_i     (quad),
    .quad_take_o(quad_take),
    .out_valid_o(vertex_o.valid),
    .out_ready_i(vertex_o.ready),
    .out_data_o (vtx)
  );

  assign vertex_o.data = vtx;

  // one table access per edge: load and character are never accepted together
  a_mem_single_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && rd_en))
    else $error("glyph table read and write in the same cycle");

  // a quad is emitted without gaps once its first vertex is taken
  a_quad_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vertex_o.valid && vertex_o.ready && (vtx.kind == KIND_VERTEX) && !vtx.last)
    |=> (vertex_o.valid && (vtx.kind == KIND_VERTEX)))
    else $error("vertex sequence broken inside a quad");

  // count reports carry no geometry and close their transaction group
  a_report_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vertex_o.valid && (vtx.kind == KIND_COUNT))
    |-> (vtx.last && (vtx.pos_x == '0) && (vtx.pos_y == '0)
         && (vtx.tex_u == '0) && (vtx.tex_v == '0)))
    else $error("count report with stray vertex fields");

  // a vertex on vertex_o never carries a nonzero count field
  a_vertex_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vertex_o.valid && (vtx.kind == KIND_VERTEX)) |-> (vtx.quad_count == '0))
    else $error("vertex carries a quad count");

endmodule

// ===== test/tb_glyph_quad_layout.sv =====
`timescale 1ns / 1ps
// tb_glyph_quad_layout: self-checking testbench of the glyph quad layout block
// a scoreboard class predicts vertex and count transactions from accepted commands
// depends on gql_pkg, gql_stream_if and glyph_quad_layout
module tb_glyph_quad_layout;
  import gql_pkg::*;

  localparam int NUM_GLYPHS      = 95;
  localparam int FIRST_PRINTABLE = 32;
  localparam int MAX_REPORTS     = 10;
  localparam int SETTLE_CYCLES   = 12;      // longer than acceptance to first vertex
  localparam int LONG_HOLD       = 300;     // receiver hold-off, fills the pipe
  localparam int CYCLE_LIMIT     = 200000;
  localparam int PHASE_ITEMS     = 25;      // useful transactions per random phase

  // predicts every vertex_o transaction from the commands accepted on item_i
  class vertex_scoreboard;
    glyph_t                  glyphs [NUM_GLYPHS];
    logic [ATLAS_W-1:0]      atlas_w;
    logic [ATLAS_W-1:0]      atlas_h;
    logic signed [POS_W-1:0] pen_x;
    logic signed [POS_W-1:0] pen_y;
    logic [CNT_W-1:0]        quads;
    vertex_t                 expected_vertices [$];
    int                      errors;

    function new();
      foreach (glyphs[i]) glyphs[i] = '0;
      atlas_w = ATLAS_RESET;
      atlas_h = ATLAS_RESET;
      pen_x   = '0;
      pen_y   = '0;
      quads   = '0;
      errors  = 0;
    endfunction

    function void set_atlas(logic [ATLAS_W-1:0] w, logic [ATLAS_W-1:0] h);
      atlas_w = w;
      atlas_h = h;
    endfunction

    function int pending();
      return expected_vertices.size();
    endfunction

    // append one predicted transaction at the tail
    function void add_expected(vertex_t v);
      expected_vertices = {expected_vertices, v};
    endfunction

    // exact value clamped to the signed Q15.4 screen range
    function logic signed [POS_W-1:0] clamp_pos(longint v);
      if (v > 524287) return 20'sh7FFFF;
      if (v < -524288) return 20'sh80000;
      return v[POS_W-1:0];
    endfunction

    function vertex_t corner(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                             logic [TEX_W-1:0] u, logic [TEX_W-1:0] v, logic last);
      vertex_t c;
      c            = '0;
      c.kind       = KIND_VERTEX;
      c.pos_x      = x;
      c.pos_y      = y;
      c.tex_u      = u;
      c.tex_v      = v;
      c.last       = last;
      return c;
    endfunction

    function void note_command(item_t it);
      glyph_t                  g;
      vertex_t                 report;
      longint                  w;
      longint                  h;
      longint                  bx;
      longint                  by;
      logic signed [POS_W-1:0] x0;
      logic signed [POS_W-1:0] x1;
      logic signed [POS_W-1:0] y0;
      logic signed [POS_W-1:0] y1;
      case (it.cmd)
        CMD_LOAD: begin
          if (it.glyph_index < NUM_GLYPHS) begin
            g.u0  = it.rect_u0;
            g.v0  = it.rect_v0;
            g.u1  = it.rect_u1;
            g.v1  = it.rect_v1;
            g.ox  = it.offset_x;
            g.oy  = it.offset_y;
            g.adv = it.advance;
            glyphs[it.glyph_index] = g;
          end
        end
        CMD_START: begin
          pen_x = it.start_x;
          pen_y = it.start_y;
          quads = '0;
        end
        CMD_END: begin
          report            = '0;
          report.kind       = KIND_COUNT;
          report.last       = 1'b1;
          report.quad_count = quads;
          add_expected(report);
        end
        default: begin
          if (it.char_code >= FIRST_PRINTABLE &&
              it.char_code < FIRST_PRINTABLE + NUM_GLYPHS) begin
            g = glyphs[it.char_code - FIRST_PRINTABLE];
            if (g.u1 > g.u0 && g.v1 > g.v0) begin
              w  = ((longint'(g.u1) - longint'(g.u0)) * longint'(atlas_w)) >>> 12;
              h  = ((longint'(g.v1) - longint'(g.v0)) * longint'(atlas_h)) >>> 12;
              bx = longint'(pen_x) + longint'(g.ox);
              by = longint'(pen_y) + longint'(g.oy);
              x0 = clamp_pos(bx);
              y0 = clamp_pos(by);
              x1 = clamp_pos(bx + w);
              y1 = clamp_pos(by + h);
              add_expected(corner(x0, y0, g.u0, g.v0, 1'b0));
              add_expected(corner(x0, y1, g.u0, g.v1, 1'b0));
              add_expected(corner(x1, y0, g.u1, g.v0, 1'b0));
              add_expected(corner(x1, y0, g.u1, g.v0, 1'b0));
              add_expected(corner(x0, y1, g.u0, g.v1, 1'b0));
              add_expected(corner(x1, y1, g.u1, g.v1, 1'b1));
              if (quads != CNT_MAX) quads = quads + CNT_W'(1);
            end
            pen_x = clamp_pos(longint'(pen_x) + longint'(g.adv));
          end
        end
      endcase
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t exp;
      if (expected_vertices.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected transaction: kind=%0d x=%0d y=%0d u=%h v=%h last=%0b cnt=%0d",
                   got.kind, got.pos_x, got.pos_y, got.tex_u, got.tex_v, got.last,
                   got.quad_count);
        return;
      end
      exp = expected_vertices.pop_front();
      if (got.kind !== exp.kind || got.pos_x !== exp.pos_x || got.pos_y !== exp.pos_y ||
          got.tex_u !== exp.tex_u || got.tex_v !== exp.tex_v || got.last !== exp.last ||
          got.quad_count !== exp.quad_count) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("vertex mismatch at %0t", $realtime);
          $display("  expected kind=%0d x=%0d y=%0d u=%h v=%h last=%0b cnt=%0d",
                   exp.kind, exp.pos_x, exp.pos_y, exp.tex_u, exp.tex_v, exp.last,
                   exp.quad_count);
          $display("  actual   kind=%0d x=%0d y=%0d u=%h v=%h last=%0b cnt=%0d",
                   got.kind, got.pos_x, got.pos_y, got.tex_u, got.tex_v, got.last,
                   got.quad_count);
        end
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [0:0]         cfg_idx_i;
  logic [ATLAS_W-1:0] cfg_wdata_i;

  gql_stream_if #(.T(item_t))   item_if ();
  gql_stream_if #(.T(vertex_t)) vertex_if ();

  vertex_scoreboard sb;
  int               useful_items;  // transactions that the block does not ignore
  int               cycles;
  int               loaded_glyphs [$];
  bit               steady;        // no idling on either side while set
  bit               hold_req;      // asks the receiver for one long hold-off

  glyph_quad_layout #(
    .GLYPH_COUNT (NUM_GLYPHS),
    .FIRST_CODE  (FIRST_PRINTABLE)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_if),
    .vertex_o    (vertex_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // every accepted command transaction updates the prediction
  always @(posedge clk_i) begin
    if (item_if.valid && item_if.ready) sb.note_command(item_if.data);
  end

  // every accepted result transaction is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (vertex_if.valid && vertex_if.ready) sb.check_vertex(vertex_if.data);
  end

  // idle length: mostly none or short, sometimes long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: random ready pattern, plus one long hold-off on request
  initial begin
    int gap;
    vertex_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        vertex_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        vertex_if.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        gap = pick_gap();
        if (gap > 0) begin
          vertex_if.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  end

  // all fields random, so unused fields of a command carry noise
  function automatic item_t random_item();
    item_t it;
    it.cmd         = cmd_e'($urandom_range(0, 3));
    it.glyph_index = GIDX_W'($urandom_range(0, 127));
    it.rect_u0     = 16'($urandom);
    it.rect_v0     = 16'($urandom);
    it.rect_u1     = 16'($urandom);
    it.rect_v1     = 16'($urandom);
    it.offset_x    = 16'($urandom);
    it.offset_y    = 16'($urandom);
    it.advance     = 16'($urandom);
    it.char_code   = CODE_W'($urandom_range(0, 255));
    it.start_x     = 20'($urandom);
    it.start_y     = 20'($urandom);
    return it;
  endfunction

  // glyph metric: half near zero, half anywhere in Q11.4
  function automatic logic signed [MET_W-1:0] random_metric();
    if ($urandom_range(0, 1) == 0) return 16'($urandom_range(0, 2047)) - 16'sd1024;
    return 16'($urandom);
  endfunction

  // pen position: mostly near the origin, sometimes anywhere in Q15.4
  function automatic logic signed [POS_W-1:0] random_pen();
    if ($urandom_range(0, 9) < 7) return 20'($urandom_range(0, 32767)) - 20'sd16384;
    return 20'($urandom);
  endfunction

  task automatic send_item(input item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid <= 1'b1;
    item_if.data  <= it;
    do @(posedge clk_i); while (!item_if.ready);
    if (!(it.cmd == CMD_LOAD && it.glyph_index >= NUM_GLYPHS) &&
        !(it.cmd == CMD_CHAR && (it.char_code < FIRST_PRINTABLE ||
                                 it.char_code >= FIRST_PRINTABLE + NUM_GLYPHS)))
      useful_items++;
  endtask

  task automatic send_load(input int idx, input logic [TEX_W-1:0] u0, input logic [TEX_W-1:0] v0,
                           input logic [TEX_W-1:0] u1, input logic [TEX_W-1:0] v1,
                           input logic signed [MET_W-1:0] ox,
                           input logic signed [MET_W-1:0] oy,
                           input logic signed [MET_W-1:0] adv);
    item_t it;
    it             = random_item();
    it.cmd         = CMD_LOAD;
    it.glyph_index = idx[GIDX_W-1:0];
    it.rect_u0     = u0;
    it.rect_v0     = v0;
    it.rect_u1     = u1;
    it.rect_v1     = v1;
    it.offset_x    = ox;
    it.offset_y    = oy;
    it.advance     = adv;
    send_item(it);
  endtask

  task automatic send_start(input logic signed [POS_W-1:0] x, input logic signed [POS_W-1:0] y);
    item_t it;
    it         = random_item();
    it.cmd     = CMD_START;
    it.start_x = x;
    it.start_y = y;
    send_item(it);
  endtask

  task automatic send_char(input int code);
    item_t it;
    it           = random_item();
    it.cmd       = CMD_CHAR;
    it.char_code = code[CODE_W-1:0];
    send_item(it);
  endtask

  task automatic send_end();
    item_t it;
    it     = random_item();
    it.cmd = CMD_END;
    send_item(it);
  endtask

  // lower valid, let all predicted results drain, then let the pipe settle
  task automatic wait_idle();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // both registers, on consecutive edges, only while idle
  task automatic program_atlas(input logic [ATLAS_W-1:0] w, input logic [ATLAS_W-1:0] h);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_ATLAS_WIDTH;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_idx_i   <= REG_ATLAS_HEIGHT;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_atlas(w, h);
    @(posedge clk_i);
  endtask

  // mostly non-empty rectangles, some empty, some loads outside the table
  task automatic send_random_load();
    int               idx;
    logic [TEX_W-1:0] u0;
    logic [TEX_W-1:0] v0;
    logic [TEX_W-1:0] u1;
    logic [TEX_W-1:0] v1;
    idx = ($urandom_range(0, 9) == 0) ? $urandom_range(NUM_GLYPHS, 127)
                                      : $urandom_range(0, NUM_GLYPHS - 1);
    u0 = TEX_W'($urandom_range(0, 65534));
    u1 = TEX_W'($urandom_range(u0 + 1, 65535));
    v0 = TEX_W'($urandom_range(0, 65534));
    v1 = TEX_W'($urandom_range(v0 + 1, 65535));
    if ($urandom_range(0, 9) == 0) u1 = TEX_W'($urandom_range(0, u0));
    if ($urandom_range(0, 9) == 0) v1 = TEX_W'($urandom_range(0, v0));
    send_load(idx, u0, v0, u1, v1, random_metric(), random_metric(), random_metric());
    if (idx < NUM_GLYPHS) loaded_glyphs = {loaded_glyphs, idx};
  endtask

  // well-formed string: start, a few characters, end
  task automatic send_random_string();
    int r;
    steady = ($urandom_range(0, 3) == 0);
    send_start(random_pen(), random_pen());
    repeat ($urandom_range(1, 8)) begin
      r = $urandom_range(0, 99);
      if (r < 80 && loaded_glyphs.size() > 0)
        send_char(loaded_glyphs[$urandom_range(0, loaded_glyphs.size() - 1)] + FIRST_PRINTABLE);
      else if (r < 90)
        send_char($urandom_range(FIRST_PRINTABLE, FIRST_PRINTABLE + NUM_GLYPHS - 1));
      else
        send_char($urandom_range(0, 255));
    end
    send_end();
    steady = 1'b0;
  endtask

  // glyph preload, then strings mixed with loads and random noise
  task automatic random_phase(input int target);
    int r;
    repeat (8) send_random_load();
    while (useful_items < target) begin
      r = $urandom_range(0, 99);
      if (r < 20) send_random_load();
      else if (r < 85) send_random_string();
      else send_item(random_item());
    end
  endtask

  initial begin
    sb            = new();
    useful_items  = 0;
    cycles        = 0;
    steady        = 1'b0;
    hold_req      = 1'b0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_ATLAS_WIDTH;
    cfg_wdata_i   <= '0;
    item_if.valid <= 1'b0;
    item_if.data  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, count report before any start
    send_end();
    send_char(65);
    // full rectangle with extreme metrics on 'A'
    send_load(33, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    // empty rectangles: zero u span on space, inverted v span on tilde
    send_load(0, 16'd100, 16'd10, 16'd100, 16'd200, 16'sd0, 16'sd0, 16'sh0100);
    send_load(94, 16'd10, 16'd300, 16'd400, 16'd299, 16'sd5, 16'sd5, 16'sh8000);
    // loads outside the table must not land anywhere
    send_load(95, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'sd1, 16'sd1, 16'sd1);
    send_load(127, 16'h1000, 16'h1000, 16'h2000, 16'h2000, 16'sd2, 16'sd2, 16'sd2);
    // pen at the corners of the screen range, positions saturate
    send_start(20'sh7FFFF, 20'sh80000);
    send_char(65);
    send_char(32);
    send_char(126);
    // unprintable codes on both sides of the printable range
    send_char(127);
    send_char(31);
    send_char(0);
    send_char(255);
    send_end();
    send_start(20'sh80000, 20'sh7FFFF);
    send_char(65);
    send_char(65);
    send_end();
    send_end();  // count is not cleared by a report

    // zero width atlas gives a zero-size quad that is still counted
    wait_idle();
    program_atlas(13'd0, 13'h1FFF);
    send_start(20'sd0, 20'sd0);
    send_char(65);
    send_end();
    wait_idle();
    program_atlas(13'd4096, 13'd1);
    send_char(65);
    send_end();

    // random phases at several atlas sizes
    wait_idle();
    program_atlas(13'd1, 13'd4096);
    random_phase(useful_items + PHASE_ITEMS);
    wait_idle();
    program_atlas(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
    hold_req = 1'b1;  // receiver stalls long while strings keep coming
    random_phase(useful_items + PHASE_ITEMS);
    wait_idle();
    program_atlas(ATLAS_RESET, ATLAS_RESET);
    random_phase(useful_items + PHASE_ITEMS);

    wait_idle();
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
